/* hdl/mdio_ms_pkg.sv */
// Shared types and constants for the clause 22 MDIO management slave.
// No dependencies; imported by mdio_management_slave.
package mdio_ms_pkg;

  // frame phases of the slave
  typedef enum logic [2:0] {
    PH_PREAMBLE  = 3'd0,
    PH_START     = 3'd1,
    PH_HEADER    = 3'd2,
    PH_WRITE     = 3'd3,
    PH_READ_TA   = 3'd4,
    PH_READ_ZERO = 3'd5,
    PH_READ_DATA = 3'd6
  } phase_t;

  // start, opcode, PHY address and register number
  localparam logic [4:0] HEADER_BITS = 5'd14;
  // turnaround plus 16 data bits
  localparam logic [4:0] WRITE_BITS  = 5'd18;
  // read data bits driven per frame
  localparam logic [4:0] DATA_BITS   = 5'd16;

  localparam logic [1:0] START_CODE = 2'b01;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_WRITE   = 2'd1;

  localparam logic [4:0]  STATUS_REG    = 5'd1;
  localparam logic [15:0] LINK_UP_VALUE = 16'h0004;

  // read value of a management register
  function automatic logic [15:0] reg_value(input logic [4:0] reg_num);
    reg_value = (reg_num == STATUS_REG) ? LINK_UP_VALUE : 16'h0000;
  endfunction

endpackage

/* hdl/mdio_management_slave.sv */
// Clause 22 MDIO management slave stepped one MDC edge event per transfer.
// Depends on mdio_ms_pkg for phase codes and register constants.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | edge event: tuser edge kind, tdata level
//  m_*     | out       | m_tvalid/m_tready  | line drive and completed write report
//  cfg_*   | in        | cfg_valid/cfg_ready| own PHY address
//
// The frame state and the result register are both loaded at the edge that
// accepts the transfer, so events may follow back to back. The result register
// stalls the input only while a result waits and m_tready is low. Reset (rst,
// synchronous) returns to waiting for preamble with the line released and the
// PHY address at 1. cfg_ready is always high.
module mdio_management_slave
  import mdio_ms_pkg::*;
#(
  parameter int PREAMBLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // edge events
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] mdio_in, [7:1] zero
  input  logic [0:0]  s_tuser,   // [0] edge_req (1 rising, 0 falling)
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] mdio_out, [5:1] write_reg, [21:6] write_data, [23:22] zero
  output logic [1:0]  m_tuser,   // [0] mdio_oe, [1] write_valid
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  // shift word holds the preamble window and at least 16 bits of data
  localparam int SHIFT_W = (PREAMBLE_BITS > 16) ? PREAMBLE_BITS : 16;
  localparam logic [SHIFT_W-1:0] PRE_MASK =
    SHIFT_W'((33'd1 << PREAMBLE_BITS) - 33'd1);
  localparam logic [SHIFT_W-1:0] LOW16_MASK = SHIFT_W'(17'h0ffff);

  // frame state
  phase_t             phase, phase_next;
  logic               output_mode, output_mode_next;
  logic [SHIFT_W-1:0] shift_word, shift_word_next;
  logic [4:0]         bit_count, bit_count_next;
  logic [4:0]         reg_select, reg_select_next;
  logic               drive_level, drive_level_next;
  logic [4:0]         phy_address;

  // result values for this event
  logic        wvalid;
  logic [4:0]  wreg;
  logic [15:0] wdata;
  logic        oe;
  logic        drive_out;

  // result register
  logic        out_valid;
  logic        out_oe, out_mdio, out_wvalid;
  logic [4:0]  out_wreg;
  logic [15:0] out_wdata;

  logic accept;
  logic rising;
  logic sample_bit;
  logic [SHIFT_W-1:0] sampled;
  logic [4:0] count_inc;

  assign s_tready   = !out_valid || m_tready;
  assign accept     = s_tvalid && s_tready;
  assign rising     = s_tuser[0];
  assign sample_bit = s_tdata[0];
  assign sampled    = {shift_word[SHIFT_W-2:0], sample_bit};
  assign count_inc  = bit_count + 5'd1;
  assign cfg_ready  = 1'b1;

  // next frame state for one edge event
  always_comb begin
    phase_next       = phase;
    output_mode_next = output_mode;
    shift_word_next  = shift_word;
    bit_count_next   = bit_count;
    reg_select_next  = reg_select;
    drive_level_next = drive_level;
    wvalid           = 1'b0;
    wreg             = 5'd0;
    wdata            = 16'd0;
    if (rising && !output_mode) begin
      shift_word_next = sampled;
      unique case (phase)
        PH_START: begin
          if (!sample_bit) begin
            bit_count_next = 5'd1;
            phase_next     = PH_HEADER;
          end
        end
        PH_HEADER: begin
          bit_count_next = count_inc;
          if (count_inc == HEADER_BITS) begin
            reg_select_next = sampled[4:0];
            if (sampled[13:12] != START_CODE ||
                (sampled[9:5] != 5'd0 && sampled[9:5] != phy_address)) begin
              phase_next = PH_PREAMBLE;
            end else if (sampled[11:10] == OP_WRITE) begin
              bit_count_next = 5'd0;
              phase_next     = PH_WRITE;
            end else if (sampled[11:10] == OP_READ) begin
              phase_next = PH_READ_TA;
            end else begin
              phase_next = PH_PREAMBLE;
            end
          end
        end
        PH_WRITE: begin
          bit_count_next = count_inc;
          if (count_inc == WRITE_BITS) begin
            wvalid     = 1'b1;
            wreg       = reg_select;
            wdata      = sampled[15:0];
            phase_next = PH_PREAMBLE;
          end
        end
        PH_READ_TA: begin
          output_mode_next = 1'b1;
          phase_next       = PH_READ_ZERO;
        end
        default: begin
          // preamble hunt, also for phases that do not sample
          if ((sampled & PRE_MASK) == PRE_MASK) begin
            phase_next = PH_START;
          end else begin
            phase_next = PH_PREAMBLE;
          end
        end
      endcase
    end else if (!rising && output_mode) begin
      if (phase == PH_READ_ZERO) begin
        drive_level_next = 1'b0;
        shift_word_next  = SHIFT_W'(reg_value(reg_select));
        bit_count_next   = 5'd0;
        phase_next       = PH_READ_DATA;
      end else if (phase == PH_READ_DATA && bit_count < DATA_BITS) begin
        drive_level_next = shift_word[15];
        shift_word_next  = (shift_word << 1) & LOW16_MASK;
        bit_count_next   = count_inc;
      end else begin
        // end of read or stray phase: release the line
        output_mode_next = 1'b0;
        drive_level_next = 1'b0;
        shift_word_next  = '0;
        phase_next       = PH_PREAMBLE;
      end
    end
  end

  // line drive after this edge
  always_comb begin
    oe        = output_mode_next && (phase_next == PH_READ_DATA);
    drive_out = oe && drive_level_next;
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_PREAMBLE;
      output_mode <= 1'b0;
      shift_word  <= '0;
      bit_count   <= 5'd0;
      reg_select  <= 5'd0;
      drive_level <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      output_mode <= output_mode_next;
      shift_word  <= shift_word_next;
      bit_count   <= bit_count_next;
      reg_select  <= reg_select_next;
      drive_level <= drive_level_next;
    end
  end

  // own address register
  always_ff @(posedge clk) begin
    if (rst) begin
      phy_address <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      phy_address <= cfg_data;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_oe     <= oe;
      out_mdio   <= drive_out;
      out_wvalid <= wvalid;
      out_wreg   <= wreg;
      out_wdata  <= wdata;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_wdata, out_wreg, out_mdio};
  assign m_tuser  = {out_wvalid, out_oe};

endmodule
